// File: src/six_word_96bit_hash_engine_top_defines.svh
// Assertion macros shared by the hash engine RTL.
// Simulation builds get the checks. Synthesis builds define SYNTH and get empty bodies.
`ifndef SIX_WORD_96BIT_HASH_ENGINE_TOP_DEFINES_SVH
`define SIX_WORD_96BIT_HASH_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTH
// This check holds at every clock edge outside reset.
`define SXH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sxh assertion failed");
// This check ties a condition to the state in the next cycle.
`define SXH_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("sxh sequence assertion failed");
`else
`define SXH_ASSERT(lbl, clk, rst_n, prop)
`define SXH_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq)
`endif

`endif

// File: src/sxh_pkg.sv
package sxh_pkg;

    // The six 32-bit words of the working set or the chaining set.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
    } work_t;

    localparam int unsigned ROUNDS   = 60;
    localparam int unsigned ROUND_W  = 6;
    localparam int unsigned BUF_WORDS = 16;

    localparam logic [31:0] K_CHOOSE   = 32'h5A82799A;
    localparam logic [31:0] K_PARITY   = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;

    localparam logic [ROUND_W-1:0] LAST_ROUND      = ROUND_W'(ROUNDS - 1);
    localparam logic [ROUND_W-1:0] PARITY_START    = ROUND_W'(20);
    localparam logic [ROUND_W-1:0] MAJORITY_START  = ROUND_W'(40);

    localparam work_t INIT_CHAIN = '{
        a: 32'h67452301,
        b: 32'hEFCDAB89,
        c: 32'h98BADCFE,
        d: 32'hC3D2A1F0,
        e: 32'h10325476,
        f: 32'h1645931C
    };

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [5:0] LEN_FIELD_POS = 6'd56;
    localparam logic [5:0] LAST_BYTE_POS = 6'd63;

endpackage

// File: src/sxh_round.sv
module sxh_round (
    input  sxh_pkg::work_t              cur,
    input  logic [31:0]                 msg_word,
    input  logic [sxh_pkg::ROUND_W-1:0] round,
    output sxh_pkg::work_t              nxt
);
    import sxh_pkg::*;

    logic [31:0] p;
    logic [31:0] k;

    // Round function and constant change every twenty rounds.
    always_comb
    begin
        if (round < PARITY_START)
        begin
            p = (cur.b & cur.c) | (~cur.b & cur.d);
            k = K_CHOOSE;
        end
        else if (round < MAJORITY_START)
        begin
            p = cur.b ^ cur.c ^ cur.d;
            k = K_PARITY;
        end
        else
        begin
            p = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
            k = K_MAJORITY;
        end
    end

    // Word f is never rewritten, so b simply takes the unchanged f.
    always_comb
    begin
        nxt.a = {cur.a[4:0], cur.a[31:5]} + p + cur.e + k + msg_word;
        nxt.b = cur.f;
        nxt.c = {cur.b[29:0], cur.b[31:30]};
        nxt.d = cur.c;
        nxt.e = cur.d;
        nxt.f = cur.f;
    end

endmodule

// File: src/six_word_96bit_hash_engine_top.sv
// Six-word 96-bit hash engine. The message enters one byte per word on the
// slave stream. tuser high marks tdata as a real byte, and tlast ends the message.
// A word with tlast and tuser low closes the message without a byte. The block
// packs the bytes big-endian into a sixteen-word block buffer. Each full
// 64-byte block runs sixty rounds through one shared round unit, one round per
// cycle. Then the ST_FINAL state adds the result into the six chaining words.
// Padding is a 0x80 byte, zero fill and the 64-bit big-endian bit count, and it
// passes through the same byte path at one byte per cycle outside compressions.
// The 96-bit digest (chaining words zero, four and five) then leaves on the
// master stream in one word. Data bytes are accepted only in the idle state.
// Every completed block holds tready low through the sixty rounds and the
// chaining add. The final word adds 9 to 72 padding bytes, with no byte
// pushed when the zero fill reaches the length field, and one or two more
// compressions. The ST_OUT state then loads the digest into the output
// register once that register is free or being read. The output register
// keeps the digest until it is taken, and the block meanwhile accepts the
// bytes of the next message.
module six_word_96bit_hash_engine_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] message_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // last_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata    // [31:0] digest_first_word,
                                        // [63:32] digest_second_word,
                                        // [95:64] digest_third_word
);
    `include "six_word_96bit_hash_engine_top_defines.svh"
    import sxh_pkg::*;

    // Sequencer states. ROUND leads to FINAL, which returns to the state saved in ret_reg.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_ZERO,
        ST_LEN,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    work_t               chain_reg, chain_next;
    work_t               work_reg, work_next;
    work_t               round_out;
    logic [ROUND_W-1:0]  round_reg, round_next;
    logic [5:0]          byte_pos_reg, byte_pos_next;
    logic [23:0]         acc_reg, acc_next;
    logic [63:0]         bit_count_reg, bit_count_next;
    logic [2:0]          len_idx_reg, len_idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [95:0]         out_data_reg, out_data_next;

    logic [31:0]         buf_mem [BUF_WORDS];
    logic [31:0]         msg_word_reg;

    logic                in_fire;
    logic                push_en;
    logic [7:0]          push_data;
    logic                block_done;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    sxh_round u_round (
        .cur      (work_reg),
        .msg_word (msg_word_reg),
        .round    (round_reg),
        .nxt      (round_out)
    );

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        round_next     = round_reg;
        byte_pos_next  = byte_pos_reg;
        acc_next       = acc_reg;
        bit_count_next = bit_count_reg;
        len_idx_next   = len_idx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        push_en        = 1'b0;
        push_data      = 8'h00;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser)
                    begin
                        push_en        = 1'b1;
                        push_data      = s_axis_tdata;
                        bit_count_next = bit_count_reg + 64'd8;
                    end
                    ret_next = s_axis_tlast ? ST_MARK : ST_IDLE;
                    if (s_axis_tlast)
                    begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK:
            begin
                push_en    = 1'b1;
                push_data  = PAD_MARK_BYTE;
                ret_next   = ST_ZERO;
                state_next = ST_ZERO;
            end
            ST_ZERO:
            begin
                if (byte_pos_reg == LEN_FIELD_POS)
                begin
                    len_idx_next = 3'd7;
                    state_next   = ST_LEN;
                end
                else
                begin
                    push_en  = 1'b1;
                    ret_next = ST_ZERO;
                end
            end
            ST_LEN:
            begin
                // The length bytes always finish the block on the last one.
                push_en      = 1'b1;
                push_data    = bit_count_reg[{len_idx_reg, 3'b000} +: 8];
                len_idx_next = len_idx_reg - 3'd1;
                ret_next     = ST_OUT;
            end
            ST_ROUND:
            begin
                work_next  = round_out;
                round_next = round_reg + ROUND_W'(1);
                if (round_reg == LAST_ROUND)
                begin
                    round_next = '0;
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                chain_next.a = chain_reg.a + work_reg.a;
                chain_next.b = chain_reg.b + work_reg.b;
                chain_next.c = chain_reg.c + work_reg.c;
                chain_next.d = chain_reg.d + work_reg.d;
                chain_next.e = chain_reg.e + work_reg.e;
                chain_next.f = chain_reg.f + work_reg.f;
                state_next   = ret_reg;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {chain_reg.f, chain_reg.e, chain_reg.a};
                    chain_next     = INIT_CHAIN;
                    bit_count_next = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Shared byte path: pack big-endian and start a compression on a full block.
        block_done = push_en && (byte_pos_reg == LAST_BYTE_POS);
        if (push_en)
        begin
            byte_pos_next = byte_pos_reg + 6'd1;
            acc_next      = {acc_reg[15:0], push_data};
        end
        if (block_done)
        begin
            work_next  = chain_reg;
            round_next = '0;
            state_next = ST_ROUND;
        end
    end

    // Message word of round i is buffer word i mod 16. There is no schedule.
    // The word for the coming round is fetched from round_next into a register.
    always_ff @(posedge clk)
    begin
        if (push_en && (byte_pos_reg[1:0] == 2'b11))
        begin
            buf_mem[byte_pos_reg[5:2]] <= {acc_reg, push_data};
        end
        msg_word_reg <= buf_mem[round_next[3:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            chain_reg     <= INIT_CHAIN;
            work_reg      <= '0;
            round_reg     <= '0;
            byte_pos_reg  <= '0;
            acc_reg       <= '0;
            bit_count_reg <= '0;
            len_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            chain_reg     <= chain_next;
            work_reg      <= work_next;
            round_reg     <= round_next;
            byte_pos_reg  <= byte_pos_next;
            acc_reg       <= acc_next;
            bit_count_reg <= bit_count_next;
            len_idx_reg   <= len_idx_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // The round counter never passes the last round.
    `SXH_ASSERT(a_round_range, clk, rst_n, round_reg <= LAST_ROUND)
    // A compression only runs on a block whose every byte slot was filled.
    `SXH_ASSERT(a_round_aligned, clk, rst_n,
        (state_reg == ST_ROUND) |-> (byte_pos_reg == 6'd0))
    // The last round is always followed by the chaining add.
    `SXH_ASSERT_NEXT(a_final_follows, clk, rst_n,
        (state_reg == ST_ROUND) && (round_reg == LAST_ROUND), state_reg == ST_FINAL)
    // A new digest leaves the block back in its fresh-message state.
    `SXH_ASSERT(a_digest_clears, clk, rst_n,
        $rose(out_valid_reg) |-> ((bit_count_reg == 64'd0) && (byte_pos_reg == 6'd0)))

endmodule
